/* hdl/bst_pkg.sv */
// ============================================================================
// bst_pkg
// Shared types and constants for the breakpoint slot table: slot count,
// BREAK word fields, RAM geometry, and the request and response structs.
// ============================================================================
package bst_pkg;

    // Slots in each of the two tables (instruction and data)
    localparam int SLOTS_PER_TABLE = 15;

    // Slot counter and RAM entry index widths
    localparam int SLOT_W  = (SLOTS_PER_TABLE > 1) ? $clog2(SLOTS_PER_TABLE) : 1;
    localparam int ENTRIES = 2 * SLOTS_PER_TABLE;
    localparam int ENTRY_W = $clog2(ENTRIES);

    // One RAM entry holds the slot address above the saved word
    localparam int WORD_W     = 32;
    localparam int RAM_DATA_W = 2 * WORD_W;

    // BREAK patch word: ((slot + base) & mask) << shift | opcode
    localparam logic [31:0] BREAK_CODE_BASE  = 32'h0000_0010;
    localparam logic [31:0] BREAK_CODE_MASK  = 32'h000F_FFFF;
    localparam logic [31:0] BREAK_OPCODE     = 32'h0000_000D;
    localparam int          BREAK_CODE_SHIFT = 6;

    // Status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Table select codes
    localparam logic TABLE_DATA  = 1'b0;
    localparam logic TABLE_INSTR = 1'b1;

    typedef struct packed {
        logic        table_select;
        logic [31:0] target_address;
        logic [31:0] original_word;
        logic [7:0]  request_tag;
        logic [31:0] request_id;
    } bst_req_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  slot_index;
        logic [31:0] saved_word;
        logic        patch_valid;
        logic [31:0] patch_word;
        logic        patch_instruction_space;
        logic [7:0]  echo_tag;
        logic [31:0] echo_id;
    } bst_rsp_t;

endpackage

/* hdl/bst_ram.sv */
// ============================================================================
// bst_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hdl/breakpoint_slot_table.sv */
// ============================================================================
// breakpoint_slot_table
// Sets software breakpoints in an instruction table or a data table of
// slots, returning the slot used and the BREAK patch word for new slots.
// ============================================================================
// A request names a table and an address. The block walks that table's slots
// in order, one slot per cycle out of a single slot RAM with a registered
// read, and stops at the first free slot or the first slot already holding
// the address; it waits on that slot while the response register is blocked.
// Accepting a request starts the read of the first slot. A free slot is
// claimed (address and original word written back) and answered with a
// patch word; a matching slot is reused unchanged; a table with neither
// answers table full and changes nothing. All slots are free after reset,
// with no clearing pass. The response sits in an output register, so a new
// request is taken while the last response waits.
module breakpoint_slot_table
    import bst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bst_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bst_rsp_t rsp
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                  state_reg;
    logic [SLOT_W-1:0]       slot_reg;
    bst_req_t                req_reg;
    logic                    rsp_valid_reg;
    bst_rsp_t                rsp_reg;
    logic [ENTRIES-1:0]      used_reg;

    logic                    req_fire;
    logic [ENTRY_W-1:0]      req_base;
    logic [ENTRY_W-1:0]      cur_base;
    logic [ENTRY_W-1:0]      cur_entry;
    logic [RAM_DATA_W-1:0]   ram_rd_data;
    logic [WORD_W-1:0]       cur_addr;
    logic [WORD_W-1:0]       cur_word;
    logic                    hit;
    logic                    fresh;
    logic                    last_slot;
    logic                    out_free;
    logic                    finish;
    logic                    advance;
    logic                    ram_wr_en;
    logic                    ram_rd_en;
    logic [ENTRY_W-1:0]      ram_rd_addr;
    logic [31:0]             slot_num;
    bst_rsp_t                rsp_next;

    // Handshake
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Entry index of the slot under test
    assign req_base  = (req.table_select == TABLE_INSTR) ? ENTRY_W'(SLOTS_PER_TABLE) : '0;
    assign cur_base  = (req_reg.table_select == TABLE_INSTR) ? ENTRY_W'(SLOTS_PER_TABLE) : '0;
    assign cur_entry = cur_base + ENTRY_W'(slot_reg);

    // Treat never-written entries as free
    assign cur_addr = used_reg[cur_entry] ? ram_rd_data[RAM_DATA_W-1:WORD_W] : '0;
    assign cur_word = used_reg[cur_entry] ? ram_rd_data[WORD_W-1:0] : '0;

    // Slot test and scan control
    assign hit       = (cur_addr == '0) || (cur_addr == req_reg.target_address);
    assign fresh     = (cur_addr == '0);
    assign last_slot = (slot_reg == SLOT_W'(SLOTS_PER_TABLE - 1));
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign finish    = (state_reg == ST_SCAN) && (hit || last_slot) && out_free;
    assign advance   = (state_reg == ST_SCAN) && !hit && !last_slot;
    assign ram_wr_en = finish && hit && fresh;

    // Read the first slot on accept, the next slot while scanning, and
    // re-read the current slot while the response register is blocked
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = cur_entry;
        if (req_fire)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = req_base;
        end
        else if ((state_reg == ST_SCAN) && !finish)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = advance ? (cur_entry + ENTRY_W'(1)) : cur_entry;
        end
    end

    bst_ram #(
        .WIDTH (RAM_DATA_W),
        .DEPTH (ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (cur_entry),
        .wr_data ({req_reg.target_address, req_reg.original_word}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Build the response for a hit or a full table
    assign slot_num = 32'(slot_reg) + 32'd1;

    always_comb
    begin
        rsp_next          = '0;
        rsp_next.echo_tag = req_reg.request_tag;
        rsp_next.echo_id  = req_reg.request_id;
        if (hit)
        begin
            rsp_next.status     = STATUS_OK;
            rsp_next.slot_index = slot_num[3:0];
            rsp_next.saved_word = fresh ? req_reg.original_word : cur_word;
            if (fresh)
            begin
                rsp_next.patch_valid = 1'b1;
                rsp_next.patch_word  =
                    (((slot_num + BREAK_CODE_BASE) & BREAK_CODE_MASK) << BREAK_CODE_SHIFT)
                    | BREAK_OPCODE;
                rsp_next.patch_instruction_space = req_reg.table_select;
            end
        end
        else
        begin
            rsp_next.status = STATUS_FULL;
        end
    end

    // State, scan counter, slot-used bits and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            req_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            used_reg      <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp_ready && !finish)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        req_reg   <= req;
                        slot_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (finish)
                    begin
                        rsp_reg       <= rsp_next;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (ram_wr_en)
                        begin
                            used_reg[cur_entry] <= 1'b1;
                        end
                    end
                    else if (advance)
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A claimed slot is reported as a successful patch in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |=> rsp_valid && (rsp.status == STATUS_OK) && rsp.patch_valid)
    else $error("slot write without a patch response");

    // A full table reports no slot and no patch
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STATUS_FULL)) |->
            (rsp.slot_index == 4'd0) && !rsp.patch_valid && (rsp.patch_word == '0))
    else $error("table-full response carries slot or patch data");

    // A blocked response is never overwritten by a finishing scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !finish)
    else $error("scan finished over a pending response");

    // The scan counter never runs past the last slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (32'(slot_reg) < 32'(SLOTS_PER_TABLE)))
    else $error("scan counter beyond last slot");

    // An accepted request starts a scan in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_SCAN) && (slot_reg == '0))
    else $error("accepted request did not start a scan");

endmodule

/* verif/bst_checker.sv */
// ============================================================================
// bst_checker
// Scoreboard for the breakpoint slot table. Watches both channels, keeps its
// own copy of both slot tables, predicts the response to every accepted
// request and compares each accepted response field by field, in order.
// ============================================================================
module bst_checker
    import bst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_ready,
    input  bst_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_ready,
    input  bst_rsp_t rsp,
    output int       mismatch_count,
    output int       pending,
    output int       rsp_count,
    output int       patch_count,
    output int       full_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow slot tables, indexed by table select then slot - 1
    logic [31:0] bp_addr [2][SLOTS_PER_TABLE];
    logic [31:0] bp_word [2][SLOTS_PER_TABLE];

    // Responses owed by the block, oldest first
    bst_rsp_t    rsp_due[$];
    bst_rsp_t    want_rsp;

    // Scan the selected table, claim a free slot, and build the response
    function automatic bst_rsp_t predict_breakpoint(input bst_req_t r);
        bst_rsp_t    o;
        int          t;
        int          hit;
        logic [31:0] slot_num;
        t   = int'(r.table_select);
        hit = -1;
        o   = '0;
        for (int i = 0; i < SLOTS_PER_TABLE; i++)
        begin
            if (hit < 0 && (bp_addr[t][i] == '0 || bp_addr[t][i] == r.target_address))
                hit = i;
        end
        o.echo_tag = r.request_tag;
        o.echo_id  = r.request_id;
        if (hit < 0)
        begin
            o.status = STATUS_FULL;
        end
        else
        begin
            slot_num = 32'(hit + 1);
            o.status = STATUS_OK;
            if (bp_addr[t][hit] == '0)
            begin
                // new slot: save the word and issue a BREAK patch
                bp_word[t][hit]           = r.original_word;
                bp_addr[t][hit]           = r.target_address;
                o.patch_valid             = 1'b1;
                o.patch_word              = (((slot_num + BREAK_CODE_BASE) & BREAK_CODE_MASK)
                                             << BREAK_CODE_SHIFT) | BREAK_OPCODE;
                o.patch_instruction_space = r.table_select;
            end
            o.slot_index = slot_num[3:0];
            o.saved_word = bp_word[t][hit];
        end
        return o;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h",
                         $realtime, fname, want, got);
        end
    endtask

    // Compare responses, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 2; t++)
            begin
                for (int i = 0; i < SLOTS_PER_TABLE; i++)
                begin
                    bp_addr[t][i] = '0;
                    bp_word[t][i] = '0;
                end
            end
            rsp_due.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_count++;
                if (rsp_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t ns: response with no request outstanding, tag 0x%02h",
                                 $realtime, rsp.echo_tag);
                end
                else
                begin
                    want_rsp = rsp_due.pop_front();
                    if (want_rsp.patch_valid)
                        patch_count++;
                    if (want_rsp.status == STATUS_FULL)
                        full_count++;
                    check_field("status", 32'(want_rsp.status), 32'(rsp.status));
                    check_field("slot_index", 32'(want_rsp.slot_index), 32'(rsp.slot_index));
                    check_field("saved_word", want_rsp.saved_word, rsp.saved_word);
                    check_field("patch_valid", 32'(want_rsp.patch_valid),
                                32'(rsp.patch_valid));
                    check_field("patch_word", want_rsp.patch_word, rsp.patch_word);
                    check_field("patch_instruction_space",
                                32'(want_rsp.patch_instruction_space),
                                32'(rsp.patch_instruction_space));
                    check_field("echo_tag", 32'(want_rsp.echo_tag), 32'(rsp.echo_tag));
                    check_field("echo_id", want_rsp.echo_id, rsp.echo_id);
                end
            end
            if (req_valid && req_ready)
                rsp_due.push_back(predict_breakpoint(req));
            pending <= rsp_due.size();
        end
    end

endmodule

/* verif/tb_breakpoint_slot_table.sv */
// ============================================================================
// tb_breakpoint_slot_table
// Stimulus and verdict for the breakpoint slot table. A directed run fills
// the data table through zero-address, reuse and table-full cases; random
// requests then fill the instruction table slowly under several idle mixes,
// a long response hold-off and drain pauses. bst_checker does the scoring.
// ============================================================================
module tb_breakpoint_slot_table;
    timeunit 1ns;
    timeprecision 1ps;
    import bst_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    bst_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bst_rsp_t rsp;

    int mismatch_count;
    int pending;
    int rsp_count;
    int patch_count;
    int full_count;

    int cycle_count   = 0;
    int sent_count    = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    // Addresses already requested, per table, for reuse hits
    logic [31:0] seen_data[$];
    logic [31:0] seen_instr[$];

    breakpoint_slot_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    bst_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .pending        (pending),
        .rsp_count      (rsp_count),
        .patch_count    (patch_count),
        .full_count     (full_count)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Drive response ready: long hold-off first, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic bst_req_t mk_req(input logic tsel, input logic [31:0] addr,
                                        input logic [31:0] word, input logic [7:0] tag,
                                        input logic [31:0] id);
        bst_req_t r;
        r.table_select   = tsel;
        r.target_address = addr;
        r.original_word  = word;
        r.request_tag    = tag;
        r.request_id     = id;
        return r;
    endfunction

    // Mostly random words, with the two extremes now and then
    function automatic logic [31:0] corner_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom();
    endfunction

    function automatic void remember_addr(input logic tsel, input logic [31:0] addr);
        if (addr == '0)
            return;
        if (tsel == TABLE_INSTR)
        begin
            foreach (seen_instr[i])
                if (seen_instr[i] == addr)
                    return;
            seen_instr.push_back(addr);
        end
        else
        begin
            foreach (seen_data[i])
                if (seen_data[i] == addr)
                    return;
            seen_data.push_back(addr);
        end
    endfunction

    // Rare fresh addresses, some zero addresses, mostly repeats of known ones
    function automatic bst_req_t random_req();
        bst_req_t r;
        int       pick;
        int       known;
        r.table_select = 1'($urandom_range(0, 1));
        known          = (r.table_select == TABLE_INSTR) ? seen_instr.size()
                                                         : seen_data.size();
        pick           = $urandom_range(0, 99);
        if (pick < 3 || known == 0)
            r.target_address = $urandom();
        else if (pick < 13)
            r.target_address = '0;
        else if (r.table_select == TABLE_INSTR)
            r.target_address = seen_instr[$urandom_range(0, known - 1)];
        else
            r.target_address = seen_data[$urandom_range(0, known - 1)];
        r.original_word = corner_word();
        r.request_tag   = 8'($urandom_range(0, 255));
        r.request_id    = corner_word();
        return r;
    endfunction

    // Offer one transaction and hold it until accepted; enter and leave on negedge
    task automatic send_req(input bst_req_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        remember_addr(item.table_select, item.target_address);
        do
            @(posedge clk);
        while (!req_ready);
        sent_count++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed response has arrived
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        repeat (count)
            send_req(random_req());
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero address on a free slot, extremes, reuse
        send_req(mk_req(TABLE_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00, 32'h0000_0000));
        send_req(mk_req(TABLE_DATA, 32'hFFFF_FFFF, 32'h0000_0000, 8'hFF, 32'hFFFF_FFFF));
        send_req(mk_req(TABLE_DATA, 32'h0000_0001, 32'h1234_5678, 8'h5A, 32'h0000_0001));
        send_req(mk_req(TABLE_DATA, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 8'hA5, 32'h0000_0002));
        send_req(mk_req(TABLE_DATA, 32'h0000_0000, 32'h5555_5555, 8'h3C, 32'h0000_0003));
        // Fill the rest of the data table, up to slot 15
        for (int k = 0; k < SLOTS_PER_TABLE - 2; k++)
            send_req(mk_req(TABLE_DATA, 32'h8000_0000 + 32'(k), $urandom(), 8'(k),
                            $urandom()));
        // Table full, for a new address and for address zero, then a reuse of slot 15
        send_req(mk_req(TABLE_DATA, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 8'h81, 32'h8000_0000));
        send_req(mk_req(TABLE_DATA, 32'h0000_0000, 32'hFFFF_FFFF, 8'h7E, 32'h7FFF_FFFF));
        send_req(mk_req(TABLE_DATA, 32'h8000_000C, 32'h0F0F_0F0F, 8'h42, 32'h0000_0042));
        // Instruction table patch
        send_req(mk_req(TABLE_INSTR, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        drain();

        // Random requests under each idle mix
        run_phase(250, 0, 0);
        run_phase(250, 77, 0);
        run_phase(250, 0, 77);
        run_phase(250, 18, 18);

        // Hold off responses while requests keep coming, so input backs up
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = HOLD_CYCLES;
        repeat (16)
            send_req(random_req());
        drain();

        run_phase(80, 18, 18);

        // Let any trailing activity settle
        repeat (40) @(posedge clk);

        $display("Sent %0d breakpoint requests, %0d responses: %0d new slots patched, %0d full",
                 sent_count, rsp_count, patch_count, full_count);
        $display("Idle mixes: none, sender, receiver, both, and a %0d-cycle response hold-off",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d responses missing", mismatch_count, pending);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
